>>> rtl/core/tpt_pkg.sv
// ----------------------------------------------------------------------------
// Pulse period tachometer package
// Shared widths, register indexes and the divider request type.
// ----------------------------------------------------------------------------
`default_nettype none

package tpt_pkg;

   // Width of the microsecond counter and of the latched period.
   localparam int COUNT_WIDTH      = 32;
   // Microsecond ticks in one minute: the dividend of the speed divide.
   localparam int TICKS_PER_MINUTE = 60000000;

   // Configuration register widths.
   localparam int POLE_WIDTH    = 7;
   localparam int TIMEOUT_WIDTH = 24;
   localparam int LIMIT_WIDTH   = 16;
   localparam int CSR_DATA_WIDTH = 24;
   localparam int CSR_INDEX_WIDTH = 2;

   // Output field width.
   localparam int RPM_WIDTH = 16;

   // Divider widths.
   localparam int TICK_WIDTH = $clog2(TICKS_PER_MINUTE + 1);
   localparam int DEN_WIDTH  = COUNT_WIDTH + POLE_WIDTH;
   localparam int CMP_WIDTH  = (DEN_WIDTH > TICK_WIDTH + 1) ? DEN_WIDTH : TICK_WIDTH + 1;
   localparam int STEP_WIDTH = $clog2(TICK_WIDTH + 1);

   // Width used for the timeout compare.
   localparam int TO_CMP_WIDTH = (COUNT_WIDTH > TIMEOUT_WIDTH) ? COUNT_WIDTH : TIMEOUT_WIDTH;

   // Register indexes on the configuration channel.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POLE_COUNT  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIMEOUT_US  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPEED_LIMIT = 2'd2;

   // Request from the sequencer to the serial divider.
   typedef struct packed {
      logic                   start;
      logic [COUNT_WIDTH-1:0] period;
      logic [POLE_WIDTH-1:0]  poles;
   } div_req_type;

endpackage

`default_nettype wire

>>> rtl/core/tpt_if.sv
// ----------------------------------------------------------------------------
// Pulse period tachometer channel interfaces
// Valid/ready channels for ticks, speed results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpt_req_if;
   logic valid;
   logic ready;
   logic pulse_level;
   logic read_request;

   modport source (output valid, output pulse_level, output read_request, input ready);
   modport sink   (input valid, input pulse_level, input read_request, output ready);
endinterface

interface tpt_rsp_if import tpt_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [RPM_WIDTH-1:0] speed_rpm;
   logic                 signal_lost;

   modport source (output valid, output speed_rpm, output signal_lost, input ready);
   modport sink   (input valid, input speed_rpm, input signal_lost, output ready);
endinterface

interface tpt_csr_if import tpt_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tpt_edge_counter.sv
// ----------------------------------------------------------------------------
// Pulse period tachometer edge counter
// Saturating microsecond counter that latches the period on falling edges.
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_edge_counter import tpt_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   tick,
   input  wire logic                   level,
   output logic [COUNT_WIDTH-1:0]      since_edge,
   output logic [COUNT_WIDTH-1:0]      period
);

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

   logic                   last_level_ff, last_level_in;
   logic [COUNT_WIDTH-1:0] since_ff, since_in;
   logic [COUNT_WIDTH-1:0] period_ff, period_in;
   logic [COUNT_WIDTH-1:0] since_inc;

   always_comb begin
      since_inc     = (since_ff != CNT_MAX) ? since_ff + 1'b1 : since_ff;
      since_in      = since_ff;
      period_in     = period_ff;
      last_level_in = last_level_ff;
      if (tick) begin
         since_in      = since_inc;
         last_level_in = level;
         // A high to low change of the line is an edge.
         if (last_level_ff && !level) begin
            period_in = since_inc;
            since_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff <= 1'b1;
         since_ff      <= '0;
         period_ff     <= '0;
      end else begin
         last_level_ff <= last_level_in;
         since_ff      <= since_in;
         period_ff     <= period_in;
      end
   end

   assign since_edge = since_ff;
   assign period     = period_ff;

endmodule

`default_nettype wire

>>> rtl/core/tpt_serial_divider.sv
// ----------------------------------------------------------------------------
// Pulse period tachometer serial divider
// Restoring divide of the ticks per minute by period times pole count.
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_serial_divider import tpt_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire div_req_type           div_req,
   output logic                       done,
   output logic [TICK_WIDTH-1:0]      quotient
);

   localparam logic [TICK_WIDTH-1:0] DIVIDEND = TICK_WIDTH'(TICKS_PER_MINUTE);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [STEP_WIDTH-1:0]  step_ff, step_in;
   logic [DEN_WIDTH-1:0]   denom_ff, denom_in;
   logic [TICK_WIDTH-1:0]  dvd_ff, dvd_in;
   logic [TICK_WIDTH-1:0]  rem_ff, rem_in;

   logic [POLE_WIDTH-1:0]  poles_eff;
   logic [TICK_WIDTH:0]    rem_shift;
   logic [CMP_WIDTH-1:0]   rem_cmp;
   logic [CMP_WIDTH-1:0]   den_cmp;
   logic [CMP_WIDTH-1:0]   diff;
   logic                   q_bit;

   always_comb begin
      // A pole count of zero counts as one.
      poles_eff = (div_req.poles == '0) ? POLE_WIDTH'(1) : div_req.poles;

      // One quotient bit per cycle: bring down the next dividend bit and try
      // to subtract the divisor.
      rem_shift = {rem_ff, dvd_ff[TICK_WIDTH-1]};
      rem_cmp   = CMP_WIDTH'(rem_shift);
      den_cmp   = CMP_WIDTH'(denom_ff);
      diff      = rem_cmp - den_cmp;
      q_bit     = (rem_cmp >= den_cmp);

      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      denom_in = denom_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;

      if (div_req.start) begin
         busy_in  = 1'b1;
         step_in  = STEP_WIDTH'(TICK_WIDTH);
         denom_in = DEN_WIDTH'(div_req.period) * DEN_WIDTH'(poles_eff);
         dvd_in   = DIVIDEND;
         rem_in   = '0;
      end else if (busy_ff) begin
         rem_in  = q_bit ? diff[TICK_WIDTH-1:0] : rem_shift[TICK_WIDTH-1:0];
         dvd_in  = {dvd_ff[TICK_WIDTH-2:0], q_bit};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      denom_ff <= denom_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

`default_nettype wire

>>> rtl/core/pulse_period_tachometer_core.sv
// ----------------------------------------------------------------------------
// Pulse period tachometer core
// Measures the pulse period in microsecond ticks and reports speed in rpm.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Beat contents
//   req_bus   in   pulse_level, read_request (one beat is one microsecond)
//   rsp_bus   out  speed_rpm, signal_lost (one beat per read request)
//   csr_bus   in   index, data (register write)
//
// A tick without a read request leaves the sequencer idle, so the block is
// ready again in the next cycle. A read that needs the divide passes through
// the accepting step, the timeout check and the divisor multiply, the
// bit-serial divider that resolves one quotient bit per cycle, its done flag
// and the hand-off into the output register. A read that times out or has no
// period yet skips the divide and goes from the check to the hand-off.
// Reset is synchronous and active high; it restores the register defaults,
// clears the counter and the period and sets the line history high.
// The next tick is accepted while a finished result still waits on rsp_bus;
// a later read then holds in its last step until the output beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_period_tachometer_core import tpt_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   tpt_req_if.sink    req_bus,
   tpt_rsp_if.source  rsp_bus,
   tpt_csr_if.sink    csr_bus
);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0] state_ff, state_in;

   // Configuration registers.
   logic [POLE_WIDTH-1:0]    pole_count_ff, pole_count_in;
   logic [TIMEOUT_WIDTH-1:0] timeout_us_ff, timeout_us_in;
   logic [LIMIT_WIDTH-1:0]   speed_limit_ff, speed_limit_in;

   // Result waiting for the output register, and the output register.
   logic [RPM_WIDTH-1:0] res_rpm_ff, res_rpm_in;
   logic                 res_lost_ff, res_lost_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RPM_WIDTH-1:0] rsp_rpm_ff, rsp_rpm_in;
   logic                 rsp_lost_ff, rsp_lost_in;

   logic                   req_accept;
   logic                   rsp_free;
   logic [COUNT_WIDTH-1:0] since_edge;
   logic [COUNT_WIDTH-1:0] period;
   logic                   timed_out;
   div_req_type            div_req;
   logic                   div_done;
   logic [TICK_WIDTH-1:0]  quotient;
   logic [TICK_WIDTH-1:0]  limit_ext;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   // The counter advances once for every accepted tick.
   tpt_edge_counter u_counter (
      .clock      (clock),
      .reset      (reset),
      .tick       (req_accept),
      .level      (req_bus.pulse_level),
      .since_edge (since_edge),
      .period     (period)
   );

   // The timeout is checked against the counter after this tick's update.
   assign timed_out = TO_CMP_WIDTH'(since_edge) > TO_CMP_WIDTH'(timeout_us_ff);

   always_comb begin
      div_req.start  = (state_ff == ST_EVAL) && !timed_out && (period != '0);
      div_req.period = period;
      div_req.poles  = pole_count_ff;
   end

   tpt_serial_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .done     (div_done),
      .quotient (quotient)
   );

   assign limit_ext = TICK_WIDTH'(speed_limit_ff);
   assign rsp_free  = !rsp_valid_ff || rsp_bus.ready;

   // Register writes; an index past the list is dropped.
   always_comb begin
      pole_count_in  = pole_count_ff;
      timeout_us_in  = timeout_us_ff;
      speed_limit_in = speed_limit_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_POLE_COUNT:  pole_count_in  = csr_bus.data[POLE_WIDTH-1:0];
            CSR_TIMEOUT_US:  timeout_us_in  = csr_bus.data[TIMEOUT_WIDTH-1:0];
            CSR_SPEED_LIMIT: speed_limit_in = csr_bus.data[LIMIT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer: check timeout and period, run the divide, clamp, hand off.
   always_comb begin
      state_in     = state_ff;
      res_rpm_in   = res_rpm_ff;
      res_lost_in  = res_lost_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_rpm_in   = rsp_rpm_ff;
      rsp_lost_in  = rsp_lost_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_bus.read_request) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            // A timeout forces zero and flags the loss; a missing period
            // gives zero without the flag. Otherwise the divide runs.
            if (timed_out || (period == '0)) begin
               res_rpm_in  = '0;
               res_lost_in = timed_out;
               state_in    = ST_DONE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_lost_in = 1'b0;
               res_rpm_in  = (quotient > limit_ext) ? speed_limit_ff
                                                    : quotient[RPM_WIDTH-1:0];
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_rpm_in   = res_rpm_ff;
               rsp_lost_in  = res_lost_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         pole_count_ff  <= POLE_WIDTH'(1);
         timeout_us_ff  <= TIMEOUT_WIDTH'(500000);
         speed_limit_ff <= LIMIT_WIDTH'(9999);
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         pole_count_ff  <= pole_count_in;
         timeout_us_ff  <= timeout_us_in;
         speed_limit_ff <= speed_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      res_rpm_ff  <= res_rpm_in;
      res_lost_ff <= res_lost_in;
      rsp_rpm_ff  <= rsp_rpm_in;
      rsp_lost_ff <= rsp_lost_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.speed_rpm   = rsp_rpm_ff;
   assign rsp_bus.signal_lost = rsp_lost_ff;

endmodule

`default_nettype wire
